@@ design/spd_pkg.sv @@
// Shared constants, types and codes for the squared-distance point sorter.
package spd_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_W    = 24;
    localparam int ID_W       = 16;
    localparam int DIST_W     = 50;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int MAG_W      = COORD_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = (SQ_W + 2 > DIST_W + 1) ? SQ_W + 2 : DIST_W + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = CFG_IDX_W'(2);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        t_point            pt;
        logic [DIST_W-1:0] dist_sq;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    localparam int POINT_W = $bits(t_point);

endpackage

@@ design/sort_points_by_distance_top.sv @@
// Top level of the squared-distance point sorter: load store, distance pipeline, sort chain.
// Loading: one point per cycle into the point RAM, input stall low while loading.
// On the marked last point of a set of n stored points, the stored points are read out and run
// through the distance pipeline into the sort chain; once the pipeline drains, the first result beat
// is offered, then one beat per cycle unless stalled. The next set is taken after the final beat.
// Synchronous active-low reset empties the store and chain and clears the origin to zero.
module sort_points_by_distance_top
    import spd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [ID_W-1:0]           i_point_id,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic                      i_last_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [ID_W-1:0]           o_sorted_id,
    output logic signed [COORD_W-1:0] o_sorted_x,
    output logic signed [COORD_W-1:0] o_sorted_y,
    output logic signed [COORD_W-1:0] o_sorted_z,
    output logic [DIST_W-1:0]         o_distance_sq,
    output logic                      o_dropped,
    output logic                      o_last_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COORD_W-1:0]        i_cfg_data
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_ovf, n_ovf;
    logic [CNT_W-1:0]          r_n, n_n;
    logic                      r_drop, n_drop;
    logic [IDX_W-1:0]          r_rd_idx, n_rd_idx;
    logic                      r_rd_v;
    logic signed [COORD_W-1:0] r_org_x, r_org_y, r_org_z;

    logic             in_acc, out_acc, has_room, ram_we, rd_en;
    logic [CNT_W-1:0] cnt_inc;
    logic             ovf_new;
    t_point           wr_point;
    logic [POINT_W-1:0] rd_data;

    logic      dist_valid, dist_busy;
    t_entry    dist_entry;
    t_cell_ctl cell_ctl;

    logic   cell_valid [MAX_POINTS];
    logic   cell_keep  [MAX_POINTS];
    t_entry cell_entry [MAX_POINTS];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_LOAD);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign has_room    = (r_count < CNT_W'(MAX_POINTS));
    assign ram_we      = in_acc && has_room;
    assign cnt_inc     = has_room ? r_count + CNT_W'(1) : r_count;
    assign ovf_new     = r_ovf | ~has_room;
    assign rd_en       = (r_state == S_READ);

    assign wr_point.id = i_point_id;
    assign wr_point.x  = i_point_x;
    assign wr_point.y  = i_point_y;
    assign wr_point.z  = i_point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ORIGIN_X: r_org_x <= i_cfg_data;
                REG_ORIGIN_Y: r_org_y <= i_cfg_data;
                REG_ORIGIN_Z: r_org_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_n      = r_n;
        n_drop   = r_drop;
        n_rd_idx = r_rd_idx;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (i_last_in) begin
                        n_count  = '0;
                        n_ovf    = 1'b0;
                        n_n      = cnt_inc;
                        n_drop   = ovf_new;
                        n_rd_idx = '0;
                        if (cnt_inc != '0) begin
                            n_state = S_READ;
                        end
                    end else begin
                        n_count = cnt_inc;
                        n_ovf   = ovf_new;
                    end
                end
            end
            S_READ: begin
                if (r_rd_idx == IDX_W'(r_n - CNT_W'(1))) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!r_rd_v && !dist_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc && o_last_out) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_rd_v  <= rd_en;
        end
        r_n      <= n_n;
        r_drop   <= n_drop;
        r_rd_idx <= n_rd_idx;
    end

    spd_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wr_point),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    spd_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_v),
        .i_point (t_point'(rd_data)),
        .i_org_x (r_org_x),
        .i_org_y (r_org_y),
        .i_org_z (r_org_z),
        .o_valid (dist_valid),
        .o_entry (dist_entry),
        .o_busy  (dist_busy)
    );

    assign cell_ctl.insert = dist_valid;
    assign cell_ctl.shift  = out_acc;

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        logic   prev_valid, prev_keep, next_valid;
        t_entry prev_entry, next_entry;

        if (g == 0) begin : g_head
            assign prev_valid = 1'b0;
            assign prev_keep  = 1'b1;
            assign prev_entry = '0;
        end else begin : g_body
            assign prev_valid = cell_valid[g-1];
            assign prev_keep  = cell_keep[g-1];
            assign prev_entry = cell_entry[g-1];
        end

        if (g == MAX_POINTS - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_entry = '0;
        end else begin : g_mid
            assign next_valid = cell_valid[g+1];
            assign next_entry = cell_entry[g+1];
        end

        spd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_new        (dist_entry),
            .i_prev_valid (prev_valid),
            .i_prev_keep  (prev_keep),
            .i_prev       (prev_entry),
            .i_next_valid (next_valid),
            .i_next       (next_entry),
            .o_valid      (cell_valid[g]),
            .o_keep       (cell_keep[g]),
            .o_entry      (cell_entry[g])
        );
    end

    assign o_out_valid   = (r_state == S_EMIT) && cell_valid[0];
    assign out_acc       = o_out_valid && !i_out_stall;
    assign o_sorted_id   = cell_entry[0].pt.id;
    assign o_sorted_x    = cell_entry[0].pt.x;
    assign o_sorted_y    = cell_entry[0].pt.y;
    assign o_sorted_z    = cell_entry[0].pt.z;
    assign o_distance_sq = cell_entry[0].dist_sq;
    assign o_dropped     = r_drop;
    assign o_last_out    = !cell_valid[1];

endmodule

@@ design/spd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/spd_dist.sv @@
// Three-stage squared-distance pipeline: abs differences, squares, saturating sum.
module spd_dist
    import spd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_point                    i_point,
    input  logic signed [COORD_W-1:0] i_org_x,
    input  logic signed [COORD_W-1:0] i_org_y,
    input  logic signed [COORD_W-1:0] i_org_z,
    output logic                      o_valid,
    output t_entry                    o_entry,
    output logic                      o_busy
);

    function automatic logic [MAG_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
        logic [MAG_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[MAG_W-1] ? (~d + 1'b1) : d;
    endfunction

    logic             r_v1, r_v2, r_v3;
    t_point           r_pt1, r_pt2;
    t_entry           r_entry3;
    logic [MAG_W-1:0] r_mag_x, r_mag_y, r_mag_z;
    logic [SQ_W-1:0]  r_sq_x, r_sq_y, r_sq_z;
    logic [SUM_W-1:0] n_sum;
    logic [DIST_W-1:0] n_dist;

    always_comb begin
        n_sum  = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
        n_dist = (n_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_pt1   <= i_point;
        r_mag_x <= abs_diff(i_point.x, i_org_x);
        r_mag_y <= abs_diff(i_point.y, i_org_y);
        r_mag_z <= abs_diff(i_point.z, i_org_z);
        r_pt2   <= r_pt1;
        r_sq_x  <= SQ_W'(r_mag_x) * SQ_W'(r_mag_x);
        r_sq_y  <= SQ_W'(r_mag_y) * SQ_W'(r_mag_y);
        r_sq_z  <= SQ_W'(r_mag_z) * SQ_W'(r_mag_z);
        r_entry3.pt      <= r_pt2;
        r_entry3.dist_sq <= n_dist;
    end

    assign o_valid = r_v3;
    assign o_entry = r_entry3;
    assign o_busy  = r_v1 | r_v2 | r_v3;

endmodule

@@ design/spd_cell.sv @@
// One cell of the insertion-sort chain: holds one entry, inserts or shifts toward the head.
module spd_cell
    import spd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  logic      i_prev_valid,
    input  logic      i_prev_keep,
    input  t_entry    i_prev,
    input  logic      i_next_valid,
    input  t_entry    i_next,
    output logic      o_valid,
    output logic      o_keep,
    output t_entry    o_entry
);

    logic   r_valid, n_valid;
    t_entry r_entry, n_entry;
    logic   keep;

    // equal distances stay ahead of the newcomer
    assign keep = r_valid && (r_entry.dist_sq <= i_new.dist_sq);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_entry = i_next;
        end else if (i_ctl.insert && !keep) begin
            if (i_prev_keep) begin
                n_valid = 1'b1;
                n_entry = i_new;
            end else begin
                n_valid = i_prev_valid;
                n_entry = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_keep  = keep;
    assign o_entry = r_entry;

endmodule

@@ design/spd_checker.sv @@
// Port-level checker for the point sorter, bound to the top level.
module spd_checker
    import spd_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [ID_W-1:0]           o_sorted_id,
    input logic [DIST_W-1:0]         o_distance_sq,
    input logic                      o_last_out
);

    // no loading while a sorted set is being emitted
    a_no_load_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while results pending");

    // results come out in ascending distance
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_out)
        |=> (o_out_valid && o_distance_sq >= $past(o_distance_sq)))
        else $error("sorted order broken");

    // nothing follows the final beat of a set
    a_end_of_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_out) |=> !o_out_valid)
        else $error("result after last beat");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
        |=> (o_out_valid && $stable(o_sorted_id) && $stable(o_distance_sq)))
        else $error("stalled result changed");

endmodule

bind sort_points_by_distance_top spd_checker u_spd_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the point sorter: directed and random point sets, stable-order check.
module testbench;
    import spd_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 60;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        t_point pt;
        logic   last;
    } t_load_beat;

    typedef struct packed {
        t_point            pt;
        logic [DIST_W-1:0] dist_sq;
        logic              dropped;
        logic              last;
    } t_ranked_pt;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic [ID_W-1:0]           i_point_id  = '0;
    logic signed [COORD_W-1:0] i_point_x   = '0;
    logic signed [COORD_W-1:0] i_point_y   = '0;
    logic signed [COORD_W-1:0] i_point_z   = '0;
    logic                      i_last_in   = 1'b0;
    logic                      i_out_stall = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [COORD_W-1:0]        i_cfg_data  = '0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [ID_W-1:0]           o_sorted_id;
    logic signed [COORD_W-1:0] o_sorted_x;
    logic signed [COORD_W-1:0] o_sorted_y;
    logic signed [COORD_W-1:0] o_sorted_z;
    logic [DIST_W-1:0]         o_distance_sq;
    logic                      o_dropped;
    logic                      o_last_out;
    logic                      o_cfg_ready;

    sort_points_by_distance_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_point_id    (i_point_id),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_last_in     (i_last_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sorted_id   (o_sorted_id),
        .o_sorted_x    (o_sorted_x),
        .o_sorted_y    (o_sorted_y),
        .o_sorted_z    (o_sorted_z),
        .o_distance_sq (o_distance_sq),
        .o_dropped     (o_dropped),
        .o_last_out    (o_last_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic signed [COORD_W-1:0] org_x = '0;
    logic signed [COORD_W-1:0] org_y = '0;
    logic signed [COORD_W-1:0] org_z = '0;
    t_point                    held_pts [MAX_POINTS];
    int                        held_cnt   = 0;
    logic                      spill_seen = 1'b0;

    t_load_beat pts_to_send [$];
    t_ranked_pt sorted_due [$];
    t_load_beat on_wire;
    t_ranked_pt want;
    logic       beat_taken;
    int         mismatches   = 0;
    int         gap_in       = 0;
    int         calm_in      = 0;
    int         stall_left   = 0;
    int         open_left    = 0;
    int         hold_left    = 0;
    logic       hold_done    = 1'b0;
    int         quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DIST_W-1:0] sq_dist(t_point p);
        longint dx, dy, dz;
        dx = longint'($signed(p.x)) - longint'(org_x);
        dy = longint'($signed(p.y)) - longint'(org_y);
        dz = longint'($signed(p.z)) - longint'(org_z);
        // at 24-bit coordinates the sum stays below 2^50, no saturation
        return DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic void load_point(t_point p, logic last);
        t_entry     ent [MAX_POINTS];
        t_entry     tmp;
        t_ranked_pt r;
        int         n, j;
        if (held_cnt < MAX_POINTS) begin
            held_pts[held_cnt] = p;
            held_cnt++;
        end else begin
            spill_seen = 1'b1;
        end
        if (!last) return;
        n = held_cnt;
        for (int i = 0; i < n; i++) begin
            ent[i].pt      = held_pts[i];
            ent[i].dist_sq = sq_dist(held_pts[i]);
        end
        // stable insertion sort, ties keep arrival order
        for (int i = 1; i < n; i++) begin
            j = i;
            while (j > 0 && ent[j-1].dist_sq > ent[j].dist_sq) begin
                tmp      = ent[j-1];
                ent[j-1] = ent[j];
                ent[j]   = tmp;
                j--;
            end
        end
        for (int i = 0; i < n; i++) begin
            r.pt      = ent[i].pt;
            r.dist_sq = ent[i].dist_sq;
            r.dropped = spill_seen;
            r.last    = (i == n - 1);
            sorted_due.insert(sorted_due.size(), r);
        end
        held_cnt   = 0;
        spill_seen = 1'b0;
    endfunction

    function automatic void push_pt(logic [ID_W-1:0] id, logic [COORD_W-1:0] x,
                                    logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, logic last);
        t_load_beat b;
        b.pt.id = id;
        b.pt.x  = x;
        b.pt.y  = y;
        b.pt.z  = z;
        b.last  = last;
        pts_to_send.insert(pts_to_send.size(), b);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(int flavor);
        case (flavor)
            0:       return COORD_W'($urandom);
            1:       return COORD_W'(int'($urandom_range(0, 600)) - 300);
            default: return COORD_W'(int'($urandom_range(0, 2)) - 1);
        endcase
    endfunction

    function automatic void queue_sets(int n_items, int big_len);
        int total, k, big_at, len, flavor;
        total  = 0;
        k      = 0;
        big_at = $urandom_range(0, 3);
        while (total < n_items) begin
            if (k == big_at) begin
                len = big_len;
            end else if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(7, 16);
            end else begin
                len = $urandom_range(1, 6);
            end
            flavor = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                push_pt(ID_W'($urandom), rand_coord(flavor), rand_coord(flavor),
                        rand_coord(flavor), i == len - 1);
            total += len;
            k++;
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp, act);
            mismatches++;
        end
    endfunction

    task automatic write_origin(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ORIGIN_X: org_x = val;
            REG_ORIGIN_Y: org_y = val;
            REG_ORIGIN_Z: org_z = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_origin(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z);
        write_origin(REG_ORIGIN_X, x);
        write_origin(REG_ORIGIN_Y, y);
        write_origin(REG_ORIGIN_Z, z);
    endtask

    // sampled at the falling edge, after the driver and monitor have settled
    task automatic drain();
        while (pts_to_send.size() != 0 || i_in_valid || sorted_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            beat_taken = i_in_valid && !o_in_stall;
            if (beat_taken) load_point(on_wire.pt, on_wire.last);
            if (!i_in_valid || beat_taken) begin
                if (gap_in > 0) begin
                    gap_in--;
                    i_in_valid <= 1'b0;
                end else if (pts_to_send.size() != 0) begin
                    on_wire = pts_to_send.pop_front();
                    i_point_id <= on_wire.pt.id;
                    i_point_x  <= on_wire.pt.x;
                    i_point_y  <= on_wire.pt.y;
                    i_point_z  <= on_wire.pt.z;
                    i_last_in  <= on_wire.last;
                    i_in_valid <= 1'b1;
                    if (calm_in > 0) begin
                        calm_in--;
                        gap_in = 0;
                    end else begin
                        gap_in = idle_len();
                        if ($urandom_range(0, 40) == 0) calm_in = 25;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall generator
    always @(posedge i_clk) begin
        if (!hold_done && o_out_valid && pts_to_send.size() > 8) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (open_left > 0) begin
            open_left--;
            i_out_stall <= 1'b0;
        end else begin
            open_left  = ($urandom_range(0, 15) == 0) ? 40 : $urandom_range(0, 6);
            stall_left = idle_len();
            i_out_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sorted_due.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got id %0h dist %0h",
                         $time, o_sorted_id, o_distance_sq);
                mismatches++;
            end else begin
                want = sorted_due.pop_front();
                check_field("sorted_id", want.pt.id, o_sorted_id);
                check_field("sorted_x", want.pt.x, o_sorted_x);
                check_field("sorted_y", want.pt.y, o_sorted_y);
                check_field("sorted_z", want.pt.z, o_sorted_z);
                check_field("distance_sq", want.dist_sq, o_distance_sq);
                check_field("dropped", want.dropped, o_dropped);
                check_field("last_out", want.last, o_last_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("** sort_points_by_distance_top: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // origin at reset: extremes, ties at equal distance, a single-point set
        push_pt(16'h0000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        push_pt(16'hFFFF, 24'h800000, 24'h800000, 24'h800000, 1'b0);
        push_pt(16'h5A5A, 24'h000000, 24'h000000, 24'h000000, 1'b0);
        push_pt(16'h0001, 24'h000001, 24'hFFFFFF, 24'h000000, 1'b0);
        push_pt(16'h0002, 24'hFFFFFF, 24'h000001, 24'h000000, 1'b0);
        push_pt(16'h0003, 24'h000000, 24'h000001, 24'hFFFFFF, 1'b0);
        push_pt(16'h0004, 24'h000000, 24'h000000, 24'h000001, 1'b1);
        push_pt(16'h8000, 24'h555555, 24'hAAAAAA, 24'h555555, 1'b1);
        drain();

        set_origin(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        push_pt(16'h000A, 24'h800000, 24'h800000, 24'h800000, 1'b0);
        push_pt(16'h000B, 24'h000000, 24'h000000, 24'h000000, 1'b0);
        push_pt(16'h000C, 24'h000000, 24'h000000, 24'h000000, 1'b0);
        push_pt(16'h000D, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
        drain();

        set_origin(24'h800000, 24'h800000, 24'h800000);
        push_pt(16'h00A0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        push_pt(16'h00A1, 24'h800000, 24'h800000, 24'h800000, 1'b0);
        push_pt(16'h00A2, 24'h000000, 24'h000000, 24'h000000, 1'b0);
        push_pt(16'h00A3, 24'h800001, 24'h800000, 24'h800000, 1'b1);
        drain();

        // random sets: one exactly at capacity, one past it
        set_origin(rand_coord(0), rand_coord(0), rand_coord(0));
        queue_sets(55, MAX_POINTS);
        drain();

        set_origin(rand_coord(1), rand_coord(1), rand_coord(1));
        queue_sets(55, $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4));
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sorted_due.size() == 0) begin
            $display("** sort_points_by_distance_top: PASSED **");
        end else begin
            $display("** sort_points_by_distance_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/spd_pkg.sv
design/spd_ram.sv
design/spd_dist.sv
design/spd_cell.sv
design/sort_points_by_distance_top.sv
design/spd_checker.sv
tb/sv/testbench.sv
